### rtl/core/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants for the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

	localparam int unsigned MAX_ROM_BANKS = 512;
	localparam int unsigned MAX_RAM_BANKS = 16;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	typedef enum logic [2:0] {
		MK_NONE = 3'd0,
		MK_MBC1 = 3'd1,
		MK_MBC2 = 3'd2,
		MK_MBC3 = 3'd3,
		MK_MBC5 = 3'd4,
		MK_HUC1 = 3'd5
	} mapper_kind_t;

	typedef enum logic [1:0] {
		TGT_NONE  = 2'd0,
		TGT_ROM   = 2'd1,
		TGT_RAM   = 2'd2,
		TGT_CLOCK = 2'd3
	} target_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAPPER_KIND   = 3'd0,
		CFG_ROM_BANK_CNT  = 3'd1,
		CFG_RAM_BANK_CNT  = 3'd2,
		CFG_MBC1_ALT_RULE = 3'd3,
		CFG_RUMBLE_FITTED = 3'd4,
		CFG_RUMBLE_DRIVE  = 3'd5
	} cfg_index_t;

	// clock register selects
	localparam logic [3:0] RTC_SEL_SEC  = 4'h8;
	localparam logic [3:0] RTC_SEL_MIN  = 4'h9;
	localparam logic [3:0] RTC_SEL_HOUR = 4'hA;
	localparam logic [3:0] RTC_SEL_DAY  = 4'hB;
	localparam logic [3:0] RTC_SEL_CTRL = 4'hC;

	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

	localparam logic [9:0] ROM_CNT_CAP = 10'(MAX_ROM_BANKS);
	localparam logic [4:0] RAM_CNT_CAP = 5'(MAX_RAM_BANKS);

endpackage

### rtl/core/cartridge_bank_controller.sv
// ----------------------------------------------------------------------------
// cartridge_bank_controller
// Decodes cartridge bus accesses, keeps the banking state and translates
// ROM, RAM and clock register accesses for several mapper kinds.
// ----------------------------------------------------------------------------
// One bus access enters on the s_ channel (tuser = op, tdata = address and
// data), one result leaves on the m_ channel (tuser = target, tdata = the
// translated address, write strobe, bytes and rumble status).
// The decode and the bank register update happen in the cycle a word is
// accepted; the result sits in the output register from the next cycle on,
// and one word can be accepted every cycle while m_tready does not stall.
// The output register is the only buffer: s_tready is high while it is
// empty or being drained, so a stall on m_tready stops intake after one
// word and nothing is lost.
// Configuration is written through cfg_wen, cfg_index and cfg_wdata while
// no access is in flight.
// Reset selects MBC1 with two ROM banks and no RAM, ROM bank 1, RAM
// disabled, clock registers and rumble cleared, and an empty output.
// ----------------------------------------------------------------------------
module cartridge_bank_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [cbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cbc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [23:0]                      s_tdata,  // address[15:0], data[23:16]
	input  logic                             s_tuser,  // op
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [47:0]                      m_tdata,  // phys_addr[22:0], write_enable[23],
	                                                   // write_data[31:24], read_data[39:32],
	                                                   // rumble[40], rumble_changed[41]
	output logic [1:0]                       m_tuser   // target
);

	// configuration
	logic [2:0]  mapper_kind_q;
	logic [9:0]  rom_bank_count_q;
	logic [4:0]  ram_bank_count_q;
	logic        mbc1_alt_q;
	logic        rumble_fitted_q;
	logic        rumble_drive_q;

	// banking state
	logic [8:0]  rom_bank_q, rom_bank_d;
	logic [3:0]  ram_select_q, ram_select_d;
	logic        ram_on_q, ram_on_d;
	logic        banking_mode_q, banking_mode_d;
	logic [7:0]  rtc_sec_q, rtc_sec_d;
	logic [7:0]  rtc_min_q, rtc_min_d;
	logic [7:0]  rtc_hour_q, rtc_hour_d;
	logic [8:0]  rtc_day_q, rtc_day_d;
	logic [7:0]  rtc_ctrl_q, rtc_ctrl_d;
	logic        last_rumble_q, last_rumble_d;

	// result register
	logic        out_valid_q;
	logic [1:0]  target_q;
	logic [22:0] phys_q;
	logic        we_q;
	logic [7:0]  wd_q;
	logic [7:0]  rd_q;
	logic        rumble_q;
	logic        changed_q;

	// decode
	cbc_pkg::mapper_kind_t kind;
	cbc_pkg::target_t      target_c;
	logic [15:0] addr;
	logic [7:0]  din;
	logic        op;
	logic        accept;
	logic [9:0]  eff_rom;
	logic [4:0]  eff_ram;
	logic        has_ram;
	logic        clock_sel;
	logic [22:0] ram_phys;
	logic [22:0] phys_c;
	logic        we_c;
	logic [7:0]  wd_c;
	logic [7:0]  rd_c;
	logic        changed_c;
	logic        rom_req;
	logic [8:0]  rom_val;
	logic        ram_req;
	logic [3:0]  ram_val;
	logic [4:0]  mbc1_low;
	logic [8:0]  nb;

	assign addr     = s_tdata[15:0];
	assign din      = s_tdata[23:16];
	assign op       = s_tuser;
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign kind = (mapper_kind_q <= 3'd5) ? cbc_pkg::mapper_kind_t'(mapper_kind_q)
	                                      : cbc_pkg::MK_NONE;
	assign eff_rom  = (rom_bank_count_q < cbc_pkg::ROM_CNT_CAP) ? rom_bank_count_q
	                                                            : cbc_pkg::ROM_CNT_CAP;
	assign eff_ram  = (ram_bank_count_q < cbc_pkg::RAM_CNT_CAP) ? ram_bank_count_q
	                                                            : cbc_pkg::RAM_CNT_CAP;
	assign has_ram  = (eff_ram != 5'd0);
	assign clock_sel = (kind == cbc_pkg::MK_MBC3) && (ram_select_q >= cbc_pkg::RTC_SEL_SEC)
	                   && (ram_select_q <= cbc_pkg::RTC_SEL_CTRL);
	assign ram_phys = {6'd0, ram_select_q, addr[12:0]};

	always_comb begin
		rom_bank_d     = rom_bank_q;
		ram_select_d   = ram_select_q;
		ram_on_d       = ram_on_q;
		banking_mode_d = banking_mode_q;
		rtc_sec_d      = rtc_sec_q;
		rtc_min_d      = rtc_min_q;
		rtc_hour_d     = rtc_hour_q;
		rtc_day_d      = rtc_day_q;
		rtc_ctrl_d     = rtc_ctrl_q;
		last_rumble_d  = last_rumble_q;
		target_c       = cbc_pkg::TGT_NONE;
		phys_c         = '0;
		we_c           = 1'b0;
		wd_c           = '0;
		rd_c           = '0;
		changed_c      = 1'b0;
		rom_req        = 1'b0;
		rom_val        = '0;
		ram_req        = 1'b0;
		ram_val        = '0;
		mbc1_low       = din[4:0];
		nb             = '0;

		if (!addr[15]) begin
			if (!op) begin
				target_c = cbc_pkg::TGT_ROM;
				if (!addr[14]) begin
					phys_c = {7'd0, addr};
				end else begin
					phys_c = {rom_bank_q, addr[13:0]};
				end
			end else if (kind != cbc_pkg::MK_NONE) begin
				unique case (addr[14:13])
					2'd0: begin
						ram_on_d = (din[3:0] == cbc_pkg::RAM_ENABLE_KEY);
					end
					2'd1: begin
						rom_req = 1'b1;
						unique case (kind)
							cbc_pkg::MK_MBC1: begin
								if (mbc1_alt_q) begin
									mbc1_low = (din[4:0] > 5'd15) ? din[4:0] - 5'd8
									                              : din[4:0];
									nb = {4'd0, mbc1_low};
								end else begin
									nb = {1'b0, rom_bank_q[7:5], din[4:0]};
								end
								rom_val = (nb != 9'd0) ? nb : 9'd1;
							end
							cbc_pkg::MK_MBC2: begin
								rom_val = (din != 8'd0) ? {1'b0, din} : 9'd1;
							end
							cbc_pkg::MK_MBC3: begin
								rom_val = (din[6:0] != 7'd0) ? {2'd0, din[6:0]} : 9'd1;
							end
							cbc_pkg::MK_MBC5: begin
								if (!addr[12]) begin
									rom_val = {rom_bank_q[8], din};
								end else begin
									rom_val = {din[0], rom_bank_q[7:0]};
								end
							end
							default: begin
								rom_val = {3'd0, din[5:0]};
							end
						endcase
					end
					2'd2: begin
						unique case (kind)
							cbc_pkg::MK_MBC1: begin
								if (!banking_mode_q) begin
									nb      = {2'd0, din[1:0], rom_bank_q[4:0]};
									rom_req = 1'b1;
									rom_val = (nb != 9'd0) ? nb : 9'd1;
								end else begin
									ram_req = 1'b1;
									ram_val = {2'd0, din[1:0]};
								end
							end
							cbc_pkg::MK_MBC3: begin
								if (din <= 8'd3) begin
									ram_req = 1'b1;
									ram_val = din[3:0];
								end else if (din >= {4'd0, cbc_pkg::RTC_SEL_SEC}
								             && din <= {4'd0, cbc_pkg::RTC_SEL_CTRL}) begin
									ram_select_d = din[3:0];
								end
							end
							cbc_pkg::MK_MBC5: begin
								ram_req = 1'b1;
								ram_val = din[3:0];
								if (rumble_fitted_q) begin
									if (rumble_drive_q && (din[3] != last_rumble_q)) begin
										changed_c     = 1'b1;
										last_rumble_d = din[3];
									end
									ram_val = {1'b0, din[2:0]};
								end
							end
							cbc_pkg::MK_HUC1: begin
								if (!banking_mode_q) begin
									rom_req = 1'b1;
									rom_val = {7'd0, din[1:0]};
								end else begin
									ram_req = 1'b1;
									ram_val = {2'd0, din[1:0]};
								end
							end
							default: begin
							end
						endcase
					end
					default: begin
						if (kind == cbc_pkg::MK_MBC1 || kind == cbc_pkg::MK_HUC1) begin
							banking_mode_d = din[0];
						end
					end
				endcase
			end
		end else if (addr[15:13] == 3'b101) begin
			if (!op) begin
				if (kind == cbc_pkg::MK_MBC3 && !ram_on_q) begin
					rd_c = 8'hFF;
				end else if (clock_sel) begin
					target_c = cbc_pkg::TGT_CLOCK;
					unique case (ram_select_q)
						cbc_pkg::RTC_SEL_SEC:  rd_c = rtc_sec_q;
						cbc_pkg::RTC_SEL_MIN:  rd_c = rtc_min_q;
						cbc_pkg::RTC_SEL_HOUR: rd_c = rtc_hour_q;
						cbc_pkg::RTC_SEL_DAY:  rd_c = rtc_day_q[7:0];
						default:               rd_c = rtc_ctrl_q;
					endcase
				end else if (has_ram) begin
					target_c = cbc_pkg::TGT_RAM;
					phys_c   = ram_phys;
				end
			end else begin
				if (ram_on_q && clock_sel) begin
					target_c = cbc_pkg::TGT_CLOCK;
					wd_c     = din;
					unique case (ram_select_q)
						cbc_pkg::RTC_SEL_SEC:  rtc_sec_d  = din;
						cbc_pkg::RTC_SEL_MIN:  rtc_min_d  = din;
						cbc_pkg::RTC_SEL_HOUR: rtc_hour_d = din;
						cbc_pkg::RTC_SEL_DAY:  rtc_day_d  = {rtc_day_q[8], din};
						default: begin
							rtc_day_d  = {din[0], rtc_day_q[7:0]};
							rtc_ctrl_d = din;
						end
					endcase
				end else if (has_ram && (kind == cbc_pkg::MK_NONE || ram_on_q)) begin
					target_c = cbc_pkg::TGT_RAM;
					phys_c   = ram_phys;
					we_c     = 1'b1;
					wd_c     = (kind == cbc_pkg::MK_MBC2) ? {4'd0, din[3:0]} : din;
				end
			end
		end

		// out-of-range bank numbers leave the bank unchanged
		if (rom_req && ({1'b0, rom_val} < eff_rom)) begin
			rom_bank_d = rom_val;
		end
		if (ram_req && ({1'b0, ram_val} < eff_ram)) begin
			ram_select_d = ram_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_kind_q    <= cbc_pkg::MK_MBC1;
			rom_bank_count_q <= 10'd2;
			ram_bank_count_q <= 5'd0;
			mbc1_alt_q       <= 1'b0;
			rumble_fitted_q  <= 1'b0;
			rumble_drive_q   <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				cbc_pkg::CFG_MAPPER_KIND:   mapper_kind_q    <= cfg_wdata[2:0];
				cbc_pkg::CFG_ROM_BANK_CNT:  rom_bank_count_q <= cfg_wdata;
				cbc_pkg::CFG_RAM_BANK_CNT:  ram_bank_count_q <= cfg_wdata[4:0];
				cbc_pkg::CFG_MBC1_ALT_RULE: mbc1_alt_q       <= cfg_wdata[0];
				cbc_pkg::CFG_RUMBLE_FITTED: rumble_fitted_q  <= cfg_wdata[0];
				cbc_pkg::CFG_RUMBLE_DRIVE:  rumble_drive_q   <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q     <= 9'd1;
			ram_select_q   <= '0;
			ram_on_q       <= 1'b0;
			banking_mode_q <= 1'b0;
			rtc_sec_q      <= '0;
			rtc_min_q      <= '0;
			rtc_hour_q     <= '0;
			rtc_day_q      <= '0;
			rtc_ctrl_q     <= '0;
			last_rumble_q  <= 1'b0;
		end else if (accept) begin
			rom_bank_q     <= rom_bank_d;
			ram_select_q   <= ram_select_d;
			ram_on_q       <= ram_on_d;
			banking_mode_q <= banking_mode_d;
			rtc_sec_q      <= rtc_sec_d;
			rtc_min_q      <= rtc_min_d;
			rtc_hour_q     <= rtc_hour_d;
			rtc_day_q      <= rtc_day_d;
			rtc_ctrl_q     <= rtc_ctrl_d;
			last_rumble_q  <= last_rumble_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			target_q  <= target_c;
			phys_q    <= phys_c;
			we_q      <= we_c;
			wd_q      <= wd_c;
			rd_q      <= rd_c;
			rumble_q  <= last_rumble_d;
			changed_q <= changed_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = target_q;
	assign m_tdata  = {6'd0, changed_q, rumble_q, rd_q, wd_q, we_q, phys_q};

endmodule

### dv/cartridge_bank_controller_tb.sv
// ----------------------------------------------------------------------------
// cartridge_bank_controller_tb
// Drives bus accesses into the cartridge bank controller under a range of
// mapper settings. An in-bench decoder tracks the bank, RAM enable, clock
// and rumble state and predicts each result word. A monitor checks every
// result field by field, in order. Both sides idle randomly before QUIET_FROM.
// ----------------------------------------------------------------------------
module cartridge_bank_controller_tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_ITEMS = 1600;
	localparam int unsigned QUIET_FROM = 1350;

	typedef struct packed {
		logic        op;
		logic [15:0] addr;
		logic [7:0]  data;
	} bus_access_t;

	typedef struct packed {
		cbc_pkg::target_t target;
		logic [22:0]      phys;
		logic             wr_en;
		logic [7:0]       wr_byte;
		logic [7:0]       rd_byte;
		logic             motor;
		logic             motor_chg;
	} bus_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_wen = 1'b0;
	logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [cbc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [23:0]                    s_tdata = '0;
	logic                           s_tuser = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [47:0]                    m_tdata;
	logic [1:0]                     m_tuser;

	cartridge_bank_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// configuration copy
	logic [2:0] cfg_kind = 3'd1;
	logic [9:0] cfg_rom_cnt = 10'd2;
	logic [4:0] cfg_ram_cnt = 5'd0;
	logic       cfg_alt = 1'b0;
	logic       cfg_rfit = 1'b0;
	logic       cfg_rdrv = 1'b0;

	// banking state
	logic [8:0] rom_bank = 9'd1;
	logic [3:0] ram_sel = 4'd0;
	logic       ram_on = 1'b0;
	logic       bank_mode = 1'b0;
	logic [7:0] rtc_sec = '0;
	logic [7:0] rtc_min = '0;
	logic [7:0] rtc_hour = '0;
	logic [8:0] rtc_day = '0;
	logic [7:0] rtc_ctrl = '0;
	logic       rumble_lvl = 1'b0;

	bus_access_t pending_accesses[$];
	bus_result_t expected_results[$];

	int unsigned fail_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned src_gap = 0;
	int unsigned snk_stall = 0;
	int unsigned queued_cnt = 0;
	int unsigned done_cnt = 0;
	logic        s_taken = 1'b0;
	logic        gaps_off = 1'b0;

	function automatic void set_rom(int unsigned bank);
		if (bank < ((cfg_rom_cnt < cbc_pkg::MAX_ROM_BANKS) ? cfg_rom_cnt
		                                                    : cbc_pkg::MAX_ROM_BANKS))
			rom_bank = bank[8:0];
	endfunction

	function automatic void set_ram(int unsigned bank);
		if (bank < ((cfg_ram_cnt < cbc_pkg::MAX_RAM_BANKS) ? cfg_ram_cnt
		                                                    : cbc_pkg::MAX_RAM_BANKS))
			ram_sel = bank[3:0];
	endfunction

	function automatic bus_result_t decode_access(logic op, logic [15:0] addr, logic [7:0] din);
		bus_result_t           r;
		cbc_pkg::mapper_kind_t mk;
		int unsigned           v;
		int unsigned           nb;
		logic                  clk_sel;
		logic                  has_ram;
		logic [22:0]           ram_addr;
		r = '0;
		r.target = cbc_pkg::TGT_NONE;
		mk = (cfg_kind <= 3'd5) ? cbc_pkg::mapper_kind_t'(cfg_kind) : cbc_pkg::MK_NONE;
		has_ram = (cfg_ram_cnt != 5'd0);
		ram_addr = 23'({ram_sel, addr[12:0]});
		clk_sel = (mk == cbc_pkg::MK_MBC3) && (ram_sel >= cbc_pkg::RTC_SEL_SEC)
		          && (ram_sel <= cbc_pkg::RTC_SEL_CTRL);
		v = din;
		if (addr[15] == 1'b0) begin
			if (op == 1'b0) begin
				r.target = cbc_pkg::TGT_ROM;
				r.phys = addr[14] ? {rom_bank, addr[13:0]} : 23'(addr);
			end else if (mk != cbc_pkg::MK_NONE) begin
				case (addr[14:13])
				2'd0: ram_on = (din[3:0] == cbc_pkg::RAM_ENABLE_KEY);
				2'd1: begin
					case (mk)
					cbc_pkg::MK_MBC1: begin
						v = v & 32'h1f;
						if (cfg_alt)
							nb = (v > 15) ? v - 8 : v;
						else
							nb = (rom_bank & 9'h0e0) | v;
						set_rom((nb != 0) ? nb : 1);
					end
					cbc_pkg::MK_MBC2: set_rom((v != 0) ? v : 1);
					cbc_pkg::MK_MBC3: begin
						v = v & 32'h7f;
						set_rom((v != 0) ? v : 1);
					end
					cbc_pkg::MK_MBC5: begin
						if (!addr[12])
							set_rom((rom_bank & 9'h100) | v);
						else
							set_rom((rom_bank & 9'h0ff) | ((v & 1) << 8));
					end
					default: set_rom(v & 32'h3f);
					endcase
				end
				2'd2: begin
					case (mk)
					cbc_pkg::MK_MBC1: begin
						v = v & 3;
						if (!bank_mode) begin
							nb = (rom_bank & 9'h01f) | (v << 5);
							set_rom((nb != 0) ? nb : 1);
						end else begin
							set_ram(v);
						end
					end
					cbc_pkg::MK_MBC3: begin
						if (v <= 3)
							set_ram(v);
						else if (v >= cbc_pkg::RTC_SEL_SEC && v <= cbc_pkg::RTC_SEL_CTRL)
							ram_sel = v[3:0];
					end
					cbc_pkg::MK_MBC5: begin
						v = v & 32'hf;
						if (cfg_rfit) begin
							if (cfg_rdrv && (v[3] != rumble_lvl)) begin
								r.motor_chg = 1'b1;
								rumble_lvl = v[3];
							end
							v = v & 7;
						end
						set_ram(v);
					end
					cbc_pkg::MK_HUC1: begin
						v = v & 3;
						if (!bank_mode)
							set_rom(v);
						else
							set_ram(v);
					end
					default: ;
					endcase
				end
				default: begin
					if (mk == cbc_pkg::MK_MBC1 || mk == cbc_pkg::MK_HUC1)
						bank_mode = din[0];
				end
				endcase
			end
		end else if (addr[15:13] == 3'b101) begin
			if (op == 1'b0) begin
				if (mk == cbc_pkg::MK_MBC3 && !ram_on) begin
					r.rd_byte = 8'hff;
				end else if (clk_sel) begin
					r.target = cbc_pkg::TGT_CLOCK;
					case (ram_sel)
					cbc_pkg::RTC_SEL_SEC:  r.rd_byte = rtc_sec;
					cbc_pkg::RTC_SEL_MIN:  r.rd_byte = rtc_min;
					cbc_pkg::RTC_SEL_HOUR: r.rd_byte = rtc_hour;
					cbc_pkg::RTC_SEL_DAY:  r.rd_byte = rtc_day[7:0];
					default:               r.rd_byte = rtc_ctrl;
					endcase
				end else if (has_ram) begin
					r.target = cbc_pkg::TGT_RAM;
					r.phys = ram_addr;
				end
			end else begin
				if (mk == cbc_pkg::MK_MBC3 && ram_on && clk_sel) begin
					r.target = cbc_pkg::TGT_CLOCK;
					r.wr_byte = din;
					case (ram_sel)
					cbc_pkg::RTC_SEL_SEC:  rtc_sec = din;
					cbc_pkg::RTC_SEL_MIN:  rtc_min = din;
					cbc_pkg::RTC_SEL_HOUR: rtc_hour = din;
					cbc_pkg::RTC_SEL_DAY:  rtc_day[7:0] = din;
					default: begin
						rtc_day[8] = din[0];
						rtc_ctrl = din;
					end
					endcase
				end else if (has_ram && (mk == cbc_pkg::MK_NONE || ram_on)) begin
					r.target = cbc_pkg::TGT_RAM;
					r.phys = ram_addr;
					r.wr_en = 1'b1;
					r.wr_byte = (mk == cbc_pkg::MK_MBC2) ? {4'h0, din[3:0]} : din;
				end
			end
		end
		r.motor = rumble_lvl;
		return r;
	endfunction

	task automatic queue_access(logic op, logic [15:0] addr, logic [7:0] data);
		bus_access_t acc;
		acc.op = op;
		acc.addr = addr;
		acc.data = data;
		pending_accesses.push_back(acc);
		queued_cnt++;
	endtask

	task automatic write_reg(cbc_pkg::cfg_index_t idx, logic [cbc_pkg::CFG_DATA_W-1:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
		cbc_pkg::CFG_MAPPER_KIND:   cfg_kind = val[2:0];
		cbc_pkg::CFG_ROM_BANK_CNT:  cfg_rom_cnt = val[9:0];
		cbc_pkg::CFG_RAM_BANK_CNT:  cfg_ram_cnt = val[4:0];
		cbc_pkg::CFG_MBC1_ALT_RULE: cfg_alt = val[0];
		cbc_pkg::CFG_RUMBLE_FITTED: cfg_rfit = val[0];
		cbc_pkg::CFG_RUMBLE_DRIVE:  cfg_rdrv = val[0];
		default: ;
		endcase
		@(negedge clk);
	endtask

	// called at a falling edge with nothing in flight; returns at a rising edge
	task automatic set_config(int unsigned kind, int unsigned romc, int unsigned ramc,
		int unsigned alt, int unsigned rfit, int unsigned rdrv);
		write_reg(cbc_pkg::CFG_MAPPER_KIND, 10'(kind));
		write_reg(cbc_pkg::CFG_ROM_BANK_CNT, 10'(romc));
		write_reg(cbc_pkg::CFG_RAM_BANK_CNT, 10'(ramc));
		write_reg(cbc_pkg::CFG_MBC1_ALT_RULE, 10'(alt));
		write_reg(cbc_pkg::CFG_RUMBLE_FITTED, 10'(rfit));
		write_reg(cbc_pkg::CFG_RUMBLE_DRIVE, 10'(rdrv));
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// every queued word has come back as a result word
	task automatic wait_drained();
		do
			@(negedge clk);
		while (done_cnt < queued_cnt);
		repeat (2) @(negedge clk);
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	// access word source
	always @(negedge clk) begin : src_drive
		bus_access_t acc;
		if (arst_n) begin
			if (!s_tvalid || s_taken) begin
				if (src_gap != 0) begin
					s_tvalid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (pending_accesses.size() != 0) begin
					acc = pending_accesses.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {acc.data, acc.addr};
					s_tuser <= acc.op;
					if (!gaps_off && $urandom_range(0, 9) == 0)
						src_gap <= $urandom_range(1, 18);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result word sink
	always @(negedge clk) begin
		if (arst_n) begin
			if (snk_stall != 0) begin
				m_tready <= 1'b0;
				snk_stall <= snk_stall - 1;
			end else begin
				m_tready <= 1'b1;
				if (!gaps_off && $urandom_range(0, 9) == 0)
					snk_stall <= $urandom_range(1, 18);
			end
		end
	end

	always @(posedge clk) begin : check_words
		bus_result_t want;
		bus_result_t got;
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("*** FAILED ***");
			$finish;
		end else begin
			s_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				done_cnt++;
				got.target = cbc_pkg::target_t'(m_tuser);
				got.phys = m_tdata[22:0];
				got.wr_en = m_tdata[23];
				got.wr_byte = m_tdata[31:24];
				got.rd_byte = m_tdata[39:32];
				got.motor = m_tdata[40];
				got.motor_chg = m_tdata[41];
				if (expected_results.size() == 0) begin
					if (fail_cnt < 10)
						$display("result word with nothing expected: tuser=%0d tdata=%h",
							m_tuser, m_tdata);
					fail_cnt++;
				end else begin
					want = expected_results.pop_front();
					if (want !== got) begin
						if (fail_cnt < 10) begin
							$display("mismatch at cycle %0d", cycle_cnt);
							$display("  expected tgt=%0d phys=%h we=%b wd=%h rd=%h rmb=%b chg=%b",
								want.target, want.phys, want.wr_en, want.wr_byte,
								want.rd_byte, want.motor, want.motor_chg);
							$display("  actual   tgt=%0d phys=%h we=%b wd=%h rd=%h rmb=%b chg=%b",
								got.target, got.phys, got.wr_en, got.wr_byte,
								got.rd_byte, got.motor, got.motor_chg);
						end
						fail_cnt++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(decode_access(s_tuser, s_tdata[15:0], s_tdata[23:16]));
		end
	end

	initial begin : stimulus
		int unsigned sent;
		int unsigned n;
		int unsigned pick;
		int unsigned romc;
		int unsigned ramc;
		logic [15:0] adr;
		logic [7:0]  dat;
		sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: two ROM banks, no RAM
		queue_access(1'b0, 16'h0000, 8'h00);
		queue_access(1'b0, 16'h7fff, 8'hff);
		queue_access(1'b0, 16'hffff, 8'h00);
		queue_access(1'b1, 16'h2000, 8'hff);
		queue_access(1'b1, 16'h2000, 8'h00);
		queue_access(1'b0, 16'ha000, 8'h00);
		wait_drained();

		// clock registers, disabled RAM read, select values that are ignored
		set_config(cbc_pkg::MK_MBC3, 512, 16, 0, 0, 0);
		queue_access(1'b0, 16'ha000, 8'h00);
		queue_access(1'b1, 16'h0000, 8'h0a);
		queue_access(1'b1, 16'h4000, 8'h08);
		queue_access(1'b1, 16'ha000, 8'h55);
		queue_access(1'b0, 16'ha000, 8'h00);
		queue_access(1'b1, 16'h4000, 8'h0c);
		queue_access(1'b1, 16'hbfff, 8'hff);
		queue_access(1'b1, 16'h4000, 8'h0b);
		queue_access(1'b0, 16'hb000, 8'h00);
		queue_access(1'b1, 16'h4000, 8'h0d);
		queue_access(1'b1, 16'h4000, 8'h05);
		queue_access(1'b1, 16'h2000, 8'h7f);
		queue_access(1'b0, 16'h7fff, 8'h00);
		queue_access(1'b1, 16'h6000, 8'h01);
		wait_drained();

		// rumble toggling and the ninth ROM bank bit
		set_config(cbc_pkg::MK_MBC5, 512, 16, 0, 1, 1);
		queue_access(1'b1, 16'h4000, 8'h0f);
		queue_access(1'b1, 16'h4000, 8'h00);
		queue_access(1'b1, 16'h3000, 8'h01);
		queue_access(1'b1, 16'h2000, 8'hff);
		queue_access(1'b0, 16'h4000, 8'h00);
		wait_drained();

		// unused mapper kind with counts past the caps
		set_config(7, 1023, 31, 1, 0, 0);
		queue_access(1'b1, 16'hbfff, 8'haa);
		queue_access(1'b0, 16'h8000, 8'h00);
		wait_drained();

		// 4-bit RAM writes
		set_config(cbc_pkg::MK_MBC2, 16, 1, 0, 0, 0);
		queue_access(1'b1, 16'h0000, 8'h0a);
		queue_access(1'b1, 16'ha123, 8'hff);
		wait_drained();

		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
			0: romc = 2;
			1: romc = 512;
			2: romc = $urandom_range(2, 64);
			default: romc = $urandom_range(0, 1023);
			endcase
			case ($urandom_range(0, 3))
			0: ramc = 0;
			1: ramc = 16;
			2: ramc = $urandom_range(1, 4);
			default: ramc = $urandom_range(0, 31);
			endcase
			set_config($urandom_range(0, 7), romc, ramc, $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 1));
			gaps_off = (sent >= QUIET_FROM);
			n = $urandom_range(10, 70);
			if ($urandom_range(0, 9) < 7) begin
				queue_access(1'b1, {3'b000, 13'($urandom)},
					{4'($urandom), cbc_pkg::RAM_ENABLE_KEY});
				sent++;
			end
			for (int i = 0; i < n; i++) begin
				pick = $urandom_range(0, 99);
				dat = 8'($urandom);
				if (pick < 30) begin
					adr = {1'b0, 2'($urandom), 13'($urandom)};
					if (adr[14:13] == 2'd0 && $urandom_range(0, 1) == 1)
						dat[3:0] = cbc_pkg::RAM_ENABLE_KEY;
					else if ($urandom_range(0, 1) == 1)
						dat = 8'($urandom_range(0, 15));
					queue_access(1'b1, adr, dat);
				end else if (pick < 65) begin
					queue_access(1'($urandom), {3'b101, 13'($urandom)}, dat);
				end else if (pick < 90) begin
					queue_access(1'b0, {1'b0, 15'($urandom)}, dat);
				end else begin
					queue_access(1'($urandom), 16'($urandom), dat);
				end
			end
			sent += n;
			wait_drained();
		end

		repeat (8) @(negedge clk);
		if (fail_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### cartridge_bank_controller.f
rtl/core/cbc_pkg.sv
rtl/core/cartridge_bank_controller.sv
dv/cartridge_bank_controller_tb.sv
